// ===== sv/dsq_pkg.sv =====
// shared types, constants and codes of the drum step sequencer
package dsq_pkg;

   localparam int WORD_W         = 27;
   localparam int VOICE_SEL_W    = 4;
   localparam int PAT_W          = 8;
   localparam int VOICES         = 11;
   localparam int ACCENT_LSB     = 16;
   localparam int MUTE_W         = 13;
   localparam int MUTE_LIMIT     = 12;
   localparam int STEP_W         = 4;
   localparam int INTERVAL_W     = 16;
   localparam int TIME_W         = 17;
   localparam int PATTERN_COUNT  = 16;
   localparam int STEPS_PER_BAR  = 16;
   localparam int RESET_INTERVAL = 125;
   localparam int RECIP_THIRD    = 43691;
   localparam int RECIP_SHIFT    = 17;
   localparam int REQ_TDATA_W    = 40;
   localparam int RSP_TDATA_W    = 80;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 16;

   localparam logic [TIME_W-1:0] RESET_RELOAD_LONG  =
      TIME_W'(RESET_INTERVAL + RESET_INTERVAL / 3);
   localparam logic [TIME_W-1:0] RESET_RELOAD_SHORT = TIME_W'((2 * RESET_INTERVAL) / 3);

   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_INTERVAL = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SWING_ENABLE  = 1'b1;

   typedef enum logic [2:0] {
      OP_TICK        = 3'd0,
      OP_START       = 3'd1,
      OP_STOP        = 3'd2,
      OP_TOGGLE_MUTE = 3'd3,
      OP_NEXT_PAT    = 3'd4,
      OP_CHAIN_ADD   = 3'd5,
      OP_CHAIN_CLEAR = 3'd6
   } op_type;

   // req tdata, lowest field last
   typedef struct packed {
      logic                   pad;
      logic [PAT_W-1:0]       pattern_number;
      logic [VOICE_SEL_W-1:0] mute_voice;
      logic [WORD_W-1:0]      step_word;
   } req_data_type;

   // rsp tdata, lowest field last
   typedef struct packed {
      logic [6:0]        pad;
      logic [MUTE_W-1:0] mutes_queued;
      logic [MUTE_W-1:0] mutes_now;
      logic              accepted;
      logic              running;
      logic              blink;
      logic [PAT_W-1:0]  queued_pattern;
      logic              queued_valid;
      logic [PAT_W-1:0]  current_pattern;
      logic [STEP_W-1:0] step_index;
      logic [VOICES-1:0] voice_accents;
      logic [VOICES-1:0] voice_triggers;
      logic              step_fired;
   } rsp_data_type;

   typedef struct packed {
      logic [INTERVAL_W-1:0] interval;
      logic                  swing;
      logic [TIME_W-1:0]     reload_long;
      logic [TIME_W-1:0]     reload_short;
   } timing_type;

   typedef struct packed {
      logic             start;
      logic             add;
      logic             clear;
      logic             advance;
      logic [PAT_W-1:0] pattern;
   } chain_cmd_type;

   typedef struct packed {
      logic             on;
      logic             add_taken;
      logic [PAT_W-1:0] first_pattern;
      logic [PAT_W-1:0] advance_pattern;
   } chain_status_type;

endpackage

// ===== sv/dsq_timing.sv =====
// step interval and swing registers with precomputed swing reload values
module dsq_timing
   import dsq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output timing_type             timing
);

   logic [INTERVAL_W-1:0] interval_ff, interval_in;
   logic                  swing_ff, swing_in;
   logic [TIME_W-1:0]     long_ff, long_in;
   logic [TIME_W-1:0]     short_ff, short_in;

   logic [32:0]           third_prod;
   logic [INTERVAL_W-1:0] third;
   logic [TIME_W-1:0]     three_third;
   logic [TIME_W-1:0]     rem_full;

   always_comb begin
      interval_in = interval_ff;
      swing_in    = swing_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_STEP_INTERVAL: interval_in = csr_wdata[INTERVAL_W-1:0];
            CSR_SWING_ENABLE:  swing_in    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // divide by three through the reciprocal, exact for 16-bit values
   always_comb begin
      third_prod  = 33'(interval_in) * 33'(RECIP_THIRD);
      third       = third_prod[RECIP_SHIFT +: INTERVAL_W];
      three_third = TIME_W'({third, 1'b0}) + TIME_W'(third);
      rem_full    = TIME_W'(interval_in) - three_third;
      long_in     = TIME_W'(interval_in) + TIME_W'(third);
      short_in    = TIME_W'({third, 1'b0}) + TIME_W'(rem_full[1:0] == 2'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_W'(RESET_INTERVAL);
         swing_ff    <= 1'b0;
         long_ff     <= RESET_RELOAD_LONG;
         short_ff    <= RESET_RELOAD_SHORT;
      end else begin
         interval_ff <= interval_in;
         swing_ff    <= swing_in;
         long_ff     <= long_in;
         short_ff    <= short_in;
      end
   end

   assign timing.interval     = interval_ff;
   assign timing.swing        = swing_ff;
   assign timing.reload_long  = long_ff;
   assign timing.reload_short = short_ff;

endmodule

// ===== sv/dsq_chain.sv =====
// pattern chain store with length, position and first-entry tracking
module dsq_chain
   import dsq_pkg::*;
#(
   parameter int CHAIN_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  chain_cmd_type    cmd,
   output chain_status_type status
);

   localparam int CLEN_W = $clog2(CHAIN_DEPTH + 1);
   localparam int CIDX_W = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;

   logic [PAT_W-1:0]  entries_ff [CHAIN_DEPTH];
   logic              on_ff, on_in;
   logic [CLEN_W-1:0] length_ff, length_in;
   logic [CIDX_W-1:0] position_ff, position_in;
   logic              before_first_ff, before_first_in;

   logic [CLEN_W-1:0] pos_inc;
   logic [CIDX_W-1:0] pos_adv;
   logic              room;
   logic              write_en;
   logic [CIDX_W-1:0] write_idx;

   always_comb begin
      pos_inc = CLEN_W'(position_ff) + CLEN_W'(1);
      if (before_first_ff || pos_inc >= length_ff) begin
         pos_adv = '0;
      end else begin
         pos_adv = pos_inc[CIDX_W-1:0];
      end
      room = length_ff < CLEN_W'(CHAIN_DEPTH);

      on_in           = on_ff;
      length_in       = length_ff;
      position_in     = position_ff;
      before_first_in = before_first_ff;
      write_en        = 1'b0;
      write_idx       = length_ff[CIDX_W-1:0];

      if (cmd.add) begin
         if (!on_ff) begin
            on_in            = 1'b1;
            length_in        = CLEN_W'(1);
            position_in      = '0;
            before_first_in  = 1'b1;
            write_en         = 1'b1;
            write_idx        = '0;
         end else if (room) begin
            length_in        = length_ff + CLEN_W'(1);
            write_en         = 1'b1;
         end
      end
      if (cmd.start) begin
         position_in     = '0;
         before_first_in = 1'b0;
      end
      if (cmd.advance) begin
         position_in     = pos_adv;
         before_first_in = 1'b0;
      end
      if (cmd.clear) begin
         on_in           = 1'b0;
         length_in       = '0;
         position_in     = '0;
         before_first_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         entries_ff[write_idx] <= cmd.pattern;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff           <= 1'b0;
         length_ff       <= '0;
         position_ff     <= '0;
         before_first_ff <= 1'b0;
      end else begin
         on_ff           <= on_in;
         length_ff       <= length_in;
         position_ff     <= position_in;
         before_first_ff <= before_first_in;
      end
   end

   // an add item would be taken now
   assign status.add_taken       = !on_ff || room;
   assign status.on              = on_ff;
   assign status.first_pattern   = entries_ff[0];
   assign status.advance_pattern = entries_ff[pos_adv];

endmodule

// ===== sv/dsq_engine.sv =====
// step timer, voice decode, mute and pattern state for one item per cycle while enabled
module dsq_engine
   import dsq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  op_type           opcode,
   input  req_data_type     data,
   input  timing_type       timing,
   input  chain_status_type chain_st,
   output chain_cmd_type    chain_cmd,
   output rsp_data_type     result
);

   logic              playing_ff, playing_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [TIME_W-1:0] remaining_ff, remaining_in;
   logic [MUTE_W-1:0] mute_mask_ff, mute_mask_in;
   logic [MUTE_W-1:0] mute_toggles_ff, mute_toggles_in;
   logic [PAT_W-1:0]  pattern_now_ff, pattern_now_in;
   logic [PAT_W-1:0]  pattern_next_ff, pattern_next_in;
   logic              pattern_next_valid_ff, pattern_next_valid_in;

   logic [TIME_W-1:0] remaining_dec;
   logic [TIME_W-1:0] reload;
   logic [STEP_W:0]   step_inc;
   logic              bar_end;
   logic [WORD_W-1:0] masked;
   logic [VOICES-1:0] decoded;
   logic [MUTE_W-1:0] mute_bit;
   logic              voice_ok;
   logic              pat_ok;
   logic              fired;
   logic [VOICES-1:0] trig;
   logic [VOICES-1:0] acc;
   logic              accepted;

   // closed hat over open hat, tom 1 over tom 2 over tom 3
   function automatic logic [VOICES-1:0] decode_voices(input logic [VOICES-1:0] w);
      logic [VOICES-1:0] t;
      t = w & 11'h783;
      if (w[2]) begin
         t[2] = 1'b1;
      end else if (w[3]) begin
         t[3] = 1'b1;
      end
      if (w[4]) begin
         t[4] = 1'b1;
      end else if (w[5]) begin
         t[5] = 1'b1;
      end else if (w[6]) begin
         t[6] = 1'b1;
      end
      return t;
   endfunction

   always_comb begin
      remaining_dec = (remaining_ff != '0) ? remaining_ff - TIME_W'(1) : '0;
      if (!timing.swing) begin
         reload = TIME_W'(timing.interval);
      end else if (!step_ff[0]) begin
         reload = timing.reload_long;
      end else begin
         reload = timing.reload_short;
      end
      step_inc = {1'b0, step_ff} + (STEP_W+1)'(1);
      bar_end  = step_inc >= (STEP_W+1)'(STEPS_PER_BAR);
      masked   = data.step_word & ~WORD_W'(mute_mask_ff);
      decoded  = decode_voices(masked[VOICES-1:0]);
      mute_bit = MUTE_W'(1) << data.mute_voice;
      voice_ok = data.mute_voice <= VOICE_SEL_W'(MUTE_LIMIT);
      pat_ok   = {1'b0, data.pattern_number} < (PAT_W+1)'(PATTERN_COUNT);
   end

   always_comb begin
      playing_in            = playing_ff;
      step_in               = step_ff;
      remaining_in          = remaining_ff;
      mute_mask_in          = mute_mask_ff;
      mute_toggles_in       = mute_toggles_ff;
      pattern_now_in        = pattern_now_ff;
      pattern_next_in       = pattern_next_ff;
      pattern_next_valid_in = pattern_next_valid_ff;
      chain_cmd             = '0;
      chain_cmd.pattern     = data.pattern_number;
      fired                 = 1'b0;
      trig                  = '0;
      acc                   = '0;
      accepted              = 1'b0;

      if (enable) begin
         unique case (opcode)
            OP_TICK: begin
               remaining_in = remaining_dec;
               if (remaining_dec == '0) begin
                  fired        = 1'b1;
                  remaining_in = reload;
                  if (playing_ff) begin
                     trig = decoded;
                     acc  = masked[ACCENT_LSB +: VOICES] & decoded;
                  end
                  step_in = step_inc[STEP_W-1:0];
                  if (bar_end) begin
                     step_in         = '0;
                     mute_mask_in    = mute_mask_ff ^ mute_toggles_ff;
                     mute_toggles_in = '0;
                     if (!chain_st.on) begin
                        if (pattern_next_valid_ff) begin
                           pattern_now_in        = pattern_next_ff;
                           pattern_next_valid_in = 1'b0;
                        end
                     end else begin
                        chain_cmd.advance = 1'b1;
                        pattern_now_in    = chain_st.advance_pattern;
                     end
                  end
               end
            end
            OP_START: begin
               playing_in = 1'b1;
               step_in    = '0;
               if (chain_st.on) begin
                  chain_cmd.start = 1'b1;
                  pattern_now_in  = chain_st.first_pattern;
               end
            end
            OP_STOP: begin
               playing_in = 1'b0;
            end
            OP_TOGGLE_MUTE: begin
               if (voice_ok) begin
                  if (playing_ff) begin
                     mute_toggles_in = mute_toggles_ff ^ mute_bit;
                     accepted        = |(mute_toggles_in & mute_bit);
                  end else begin
                     mute_mask_in = mute_mask_ff ^ mute_bit;
                     accepted     = |(mute_mask_in & mute_bit);
                  end
               end
            end
            OP_NEXT_PAT: begin
               if (pat_ok && data.pattern_number != pattern_now_ff) begin
                  accepted = 1'b1;
                  if (playing_ff) begin
                     pattern_next_in       = data.pattern_number;
                     pattern_next_valid_in = 1'b1;
                  end else begin
                     pattern_now_in = data.pattern_number;
                  end
               end
            end
            OP_CHAIN_ADD: begin
               chain_cmd.add = pat_ok;
               accepted      = pat_ok && chain_st.add_taken;
            end
            OP_CHAIN_CLEAR: begin
               chain_cmd.clear = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         playing_ff            <= 1'b0;
         step_ff               <= '0;
         remaining_ff          <= '0;
         mute_mask_ff          <= '0;
         mute_toggles_ff       <= '0;
         pattern_now_ff        <= '0;
         pattern_next_ff       <= '0;
         pattern_next_valid_ff <= 1'b0;
      end else begin
         playing_ff            <= playing_in;
         step_ff               <= step_in;
         remaining_ff          <= remaining_in;
         mute_mask_ff          <= mute_mask_in;
         mute_toggles_ff       <= mute_toggles_in;
         pattern_now_ff        <= pattern_now_in;
         pattern_next_ff       <= pattern_next_in;
         pattern_next_valid_ff <= pattern_next_valid_in;
      end
   end

   always_comb begin
      result                 = '0;
      result.step_fired      = fired;
      result.voice_triggers  = trig;
      result.voice_accents   = acc;
      result.step_index      = step_in;
      result.current_pattern = pattern_now_in;
      result.queued_valid    = pattern_next_valid_in;
      result.queued_pattern  = pattern_next_in;
      result.blink           = remaining_in > TIME_W'(timing.interval >> 1);
      result.running         = playing_in;
      result.accepted        = accepted;
      result.mutes_now       = mute_mask_in;
      result.mutes_queued    = mute_toggles_in;
   end

endmodule

// ===== sv/drum_step_sequencer.sv =====
// sixteen-step drum sequencer top level with input and result registers
// an accepted req item is held in the input register, and its result in the result register that drives rsp
// throughput: one item per cycle while rsp is not stalled, limited by the single-pass engine stage
// reset clears timer, step, mutes, patterns and chain control; first tick fires
// chain entries are not cleared and hold no value until written
// swing reload values are registered together with the interval they come from
module drum_step_sequencer
   import dsq_pkg::*;
#(
   parameter int CHAIN_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // step_word, mute_voice, pattern_number, pad
   input  logic [2:0]             req_tuser,   // opcode
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // step_fired, voice_triggers, voice_accents,
                                               // step_index, current_pattern, queued_valid,
                                               // queued_pattern, blink, running, accepted,
                                               // mutes_now, mutes_queued, pad
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic             in_valid_ff, in_valid_in;
   op_type           in_op_ff, in_op_in;
   req_data_type     in_data_ff, in_data_in;
   logic             out_valid_ff, out_valid_in;
   rsp_data_type     out_data_ff, out_data_in;

   logic             advance;
   timing_type       timing;
   chain_cmd_type    chain_cmd;
   chain_status_type chain_st;
   rsp_data_type     result;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_op_in     = in_op_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_op_in    = op_type'(req_tuser);
         in_data_in  = req_data_type'(req_tdata);
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = result;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_op_ff    <= in_op_in;
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   dsq_timing u_timing (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .timing    (timing)
   );

   dsq_chain #(
      .CHAIN_DEPTH (CHAIN_DEPTH)
   ) u_chain (
      .clock  (clock),
      .reset  (reset),
      .cmd    (chain_cmd),
      .status (chain_st)
   );

   dsq_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .opcode    (in_op_ff),
      .data      (in_data_ff),
      .timing    (timing),
      .chain_st  (chain_st),
      .chain_cmd (chain_cmd),
      .result    (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
